// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the block pool allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define FBPA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fbpa: assertion failed");
// Expression must never be true outside reset.
`define FBPA_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("fbpa: forbidden condition seen");
`else
`define FBPA_ASSERT(label, clk, rst_n, prop)
`define FBPA_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

// ===== rtl/fbpa_pkg.sv =====
// Shared types and constants of the fixed block pool allocator.
package fbpa_pkg;

    // Field widths
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 16;
    localparam int CNT_W      = 9;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Offsets inside the pool are below size * count
    localparam int SPAN_W = SIZE_W + CNT_W;
    // Divider step counter, one quotient bit per step
    localparam int STEP_W = $clog2(CNT_W);

    localparam int unsigned MAX_BLOCKS_DEF = 256;

    // Smallest block size honored
    localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(4);

    // Operation codes
    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DOUBLE   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] block_addr;
    } fbpa_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   granted_addr;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    free_left;
    } fbpa_rsp_t;

endpackage

// ===== rtl/fbpa_stream_if.sv =====
// Valid/ready stream channel carrying one payload word.
interface fbpa_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

// ===== rtl/fbpa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/fixed_block_pool_allocator.sv =====
// Fixed block pool allocator top level. Each request word is an allocate or a free and
// gives one response word. The free list is a LIFO held as a head index plus one RAM
// entry per block ({free mark, link}); after reset or a register write every block is
// free, chained downward from the top, and this is tracked by a fresh-block watermark so
// no clearing pass over the RAM is needed (the block accepts no request while the head
// and counts are reloaded after reset or a register write). An allocate on a non-empty
// pool goes from acceptance to the response register by RAM read of the head, write
// back, multiply of index by block size, add of the base. A free does an offset and
// range check and, if it passes, a restoring divider that produces one of the 9 quotient
// bits per cycle, then a RAM read-modify-write of the block's entry. One request is in work at
// a time; a finished response waits in the output register, and the next request is
// accepted even while it is still unread.
`include "assert_macros.svh"

module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    fbpa_stream_if.sink           req,
    fbpa_stream_if.source         rsp
);

    localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CMP_W   = (IDX_W > CNT_W) ? IDX_W : CNT_W;
    localparam int PROD_W  = SIZE_W + IDX_W;
    localparam int ENTRY_W = IDX_W + 1;
    // Largest count the pool honors: built depth, or what the count register can hold
    localparam int unsigned CAP = (MAX_BLOCKS < ((1 << CNT_W) - 1)) ?
                                  MAX_BLOCKS : ((1 << CNT_W) - 1);
    localparam logic [CNT_W-1:0] CAP_N = CNT_W'(CAP);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_AREQ  = 9'b000000010,
        S_AWR   = 9'b000000100,
        S_AADD  = 9'b000001000,
        S_FCHK  = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_FCHK2 = 9'b001000000,
        S_FWR   = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    // Configuration
    logic [ADDR_W-1:0] base_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              cfg_hit;

    // Control state
    state_t            state_reg, state_next;
    logic              rebuild_reg, rebuild_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  fresh_reg, fresh_next;
    logic              out_valid_reg, out_valid_next;
    logic              load_out;

    // Datapath
    logic                addr_zero_reg;
    logic [ADDR_W-1:0]   offset_reg;
    logic [SPAN_W-1:0]   span_reg;
    logic [SPAN_W-1:0]   rem_reg;
    logic [SPAN_W-1:0]   dvs_reg;
    logic [CNT_W-1:0]    q_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ADDR_W-1:0]   res_addr_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [CNT_W-1:0]    out_left_reg;

    // Effective settings and derived flags
    logic [SIZE_W-1:0] size_eff;
    logic [CNT_W-1:0]  n_eff;
    logic              head_fresh;
    logic              q_fresh;
    logic [IDX_W-1:0]  q_idx;
    logic              accept;

    // RAM ports
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    fbpa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_list_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Clamp settings to the honored range
    always_comb
    begin
        size_eff = (size_reg < MIN_SIZE) ? MIN_SIZE : size_reg;
        if (count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (count_reg > CAP_N)
        begin
            n_eff = CAP_N;
        end
        else
        begin
            n_eff = count_reg;
        end
    end

    // Blocks below the watermark are still in their post-rebuild chain
    assign head_fresh = CMP_W'(head_reg) < CMP_W'(fresh_reg);
    assign q_fresh    = q_reg < fresh_reg;
    assign q_idx      = IDX_W'(q_reg);
    assign cfg_hit    = cfg_we && (cfg_idx inside {CFG_BASE_ADDR, CFG_BLOCK_SIZE,
                                                   CFG_BLOCK_COUNT});
    assign accept     = req.valid && req.ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            size_reg  <= SIZE_W'(4);
            count_reg <= CNT_W'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_BASE_ADDR:   base_reg  <= cfg_wdata[ADDR_W-1:0];
                CFG_BLOCK_SIZE:  size_reg  <= cfg_wdata[SIZE_W-1:0];
                CFG_BLOCK_COUNT: count_reg <= cfg_wdata[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Sequencer and RAM access
    always_comb
    begin
        state_next     = state_reg;
        rebuild_next   = rebuild_reg;
        head_next      = head_reg;
        total_next     = total_reg;
        fresh_next     = fresh_reg;
        out_valid_next = out_valid_reg;
        load_out       = 1'b0;
        req.ready      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = head_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = head_reg;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (rebuild_reg)
                begin
                    // Reload the list: chain from n-1 down to 0, all free
                    head_next    = IDX_W'(n_eff - CNT_W'(1));
                    total_next   = n_eff;
                    fresh_next   = n_eff;
                    rebuild_next = 1'b0;
                end
                else
                begin
                    req.ready = 1'b1;
                    if (req.valid)
                    begin
                        if (req.payload.func == FN_ALLOC)
                        begin
                            state_next = (total_reg == '0) ? S_DONE : S_AREQ;
                        end
                        else
                        begin
                            state_next = S_FCHK;
                        end
                    end
                end
            end
            S_AREQ:
            begin
                ram_re     = 1'b1;
                ram_raddr  = head_reg;
                state_next = S_AWR;
            end
            S_AWR:
            begin
                // Pop the head and clear its free mark
                ram_we     = 1'b1;
                ram_waddr  = head_reg;
                ram_wdata  = {1'b0, ram_rdata[IDX_W-1:0]};
                total_next = total_reg - CNT_W'(1);
                if (head_fresh)
                begin
                    fresh_next = fresh_reg - CNT_W'(1);
                    head_next  = (head_reg == '0) ? '0 : head_reg - IDX_W'(1);
                end
                else
                begin
                    head_next = ram_rdata[IDX_W-1:0];
                end
                state_next = S_AADD;
            end
            S_AADD:
            begin
                state_next = S_DONE;
            end
            S_FCHK:
            begin
                if (addr_zero_reg || (offset_reg >= ADDR_W'(span_reg)))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = S_FCHK2;
                end
            end
            S_FCHK2:
            begin
                if ((rem_reg != '0) || (total_reg >= n_eff) || q_fresh)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = q_idx;
                    state_next = S_FWR;
                end
            end
            S_FWR:
            begin
                // Push the block unless it is already marked free
                if (!ram_rdata[IDX_W])
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = q_idx;
                    ram_wdata  = {1'b1, head_reg};
                    head_next  = q_idx;
                    total_next = total_reg + CNT_W'(1);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Any register write rebuilds the pool
        if (cfg_hit)
        begin
            rebuild_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rebuild_reg   <= 1'b1;
            head_reg      <= '0;
            total_reg     <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rebuild_reg   <= rebuild_next;
            head_reg      <= head_next;
            total_reg     <= total_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath: checks, divider, address math
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    addr_zero_reg  <= (req.payload.block_addr == '0);
                    offset_reg     <= req.payload.block_addr - base_reg;
                    span_reg       <= SPAN_W'(size_eff) * SPAN_W'(n_eff);
                    res_addr_reg   <= '0;
                    res_status_reg <= ((req.payload.func == FN_ALLOC) && (total_reg == '0)) ?
                                      ST_NONE : ST_OK;
                end
            end
            S_AWR:
            begin
                prod_reg <= PROD_W'(size_eff) * PROD_W'(head_reg);
            end
            S_AADD:
            begin
                res_addr_reg <= base_reg + ADDR_W'(prod_reg);
            end
            S_FCHK:
            begin
                if (addr_zero_reg)
                begin
                    res_status_reg <= ST_NONE;
                end
                else if (offset_reg >= ADDR_W'(span_reg))
                begin
                    res_status_reg <= ST_BAD_ADDR;
                end
                rem_reg  <= SPAN_W'(offset_reg);
                dvs_reg  <= SPAN_W'(size_eff) << (CNT_W - 1);
                q_reg    <= '0;
                step_reg <= STEP_W'(CNT_W - 1);
            end
            S_DIV:
            begin
                // Restoring division, one quotient bit per cycle
                if (rem_reg >= dvs_reg)
                begin
                    rem_reg <= rem_reg - dvs_reg;
                    q_reg   <= {q_reg[CNT_W-2:0], 1'b1};
                end
                else
                begin
                    q_reg <= {q_reg[CNT_W-2:0], 1'b0};
                end
                dvs_reg  <= dvs_reg >> 1;
                step_reg <= step_reg - STEP_W'(1);
            end
            S_FCHK2:
            begin
                if (rem_reg != '0)
                begin
                    res_status_reg <= ST_BAD_ADDR;
                end
                else if ((total_reg >= n_eff) || q_fresh)
                begin
                    res_status_reg <= ST_DOUBLE;
                end
            end
            S_FWR:
            begin
                if (ram_rdata[IDX_W])
                begin
                    res_status_reg <= ST_DOUBLE;
                end
            end
            default:
            begin
            end
        endcase

        if (load_out)
        begin
            out_addr_reg   <= res_addr_reg;
            out_status_reg <= res_status_reg;
            out_left_reg   <= total_reg;
        end
    end

    // Response word
    assign rsp.valid                = out_valid_reg;
    assign rsp.payload.granted_addr = out_addr_reg;
    assign rsp.payload.status       = out_status_reg;
    assign rsp.payload.free_left    = out_left_reg;

    // Checks
    `FBPA_ASSERT(a_total_bound, clk, rst_n, !rebuild_reg |-> total_reg <= n_eff)
    `FBPA_ASSERT(a_fresh_free, clk, rst_n, !rebuild_reg |-> fresh_reg <= total_reg)
    `FBPA_ASSERT(a_alloc_count, clk, rst_n, state_reg == S_AWR |=> total_reg == $past(total_reg) - CNT_W'(1))
    `FBPA_ASSERT_NEVER(a_pop_empty, clk, rst_n, state_reg == S_AREQ && total_reg == '0)

endmodule

// ===== test/fbpa_pool_checker.sv =====
// Checker for the block pool allocator: tracks the pool, predicts each response word, compares.
`timescale 1ns / 1ps

module fbpa_pool_checker
    import fbpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  req_valid,
    input  logic                  req_ready,
    input  fbpa_req_t             req_word,
    input  logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  fbpa_rsp_t             rsp_word,
    output int unsigned           errors,
    output int unsigned           waiting
);

    localparam int unsigned DEPTH = MAX_BLOCKS_DEF;
    localparam int IDX_W = $clog2(DEPTH);

    // Register copies
    logic [ADDR_W-1:0] base_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [CNT_W-1:0]  count_reg;

    // Free list copy
    logic [IDX_W-1:0] link [DEPTH];
    logic             is_free [DEPTH];
    logic [IDX_W-1:0] head;
    logic [CNT_W-1:0] free_cnt;

    fbpa_rsp_t   expected_rsp[$];
    fbpa_rsp_t   due_word;
    int unsigned mismatches;

    function automatic logic [ADDR_W-1:0] used_size();
        return (size_reg < MIN_SIZE) ? ADDR_W'(MIN_SIZE) : ADDR_W'(size_reg);
    endfunction

    function automatic logic [ADDR_W-1:0] used_count();
        if (count_reg == '0)
            return ADDR_W'(1);
        if (count_reg > CNT_W'(DEPTH))
            return ADDR_W'(DEPTH);
        return ADDR_W'(count_reg);
    endfunction

    // Every block of the pool free, chained downward from the top
    function automatic void rebuild_pool();
        logic [ADDR_W-1:0] n;
        n = used_count();
        for (int i = 0; i < DEPTH; i++)
        begin
            link[i] = (i == 0) ? '0 : IDX_W'(i - 1);
            is_free[i] = (i < n);
        end
        head = IDX_W'(n - 1);
        free_cnt = CNT_W'(n);
    endfunction

    // Apply one request word to the pool and return the response word it gives
    function automatic fbpa_rsp_t serve_request(fbpa_req_t r);
        fbpa_rsp_t         o;
        logic [ADDR_W-1:0] sz;
        logic [ADDR_W-1:0] n;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] idx;
        sz = used_size();
        n = used_count();
        o.granted_addr = '0;
        o.status = ST_OK;
        if (r.func == FN_ALLOC)
        begin
            if (free_cnt == '0)
                o.status = ST_NONE;
            else
            begin
                idx = ADDR_W'(head);
                o.granted_addr = base_reg + idx * sz;
                head = link[idx];
                is_free[idx] = 1'b0;
                free_cnt = free_cnt - 1'b1;
            end
        end
        else
        begin
            offset = r.block_addr - base_reg;
            if (r.block_addr == '0)
                o.status = ST_NONE;
            else if (offset >= sz * n)
                o.status = ST_BAD_ADDR;
            else if (offset % sz != '0)
                o.status = ST_BAD_ADDR;
            else if (ADDR_W'(free_cnt) >= n)
                o.status = ST_DOUBLE;
            else
            begin
                idx = offset / sz;
                if (is_free[idx])
                    o.status = ST_DOUBLE;
                else
                begin
                    link[idx] = head;
                    head = IDX_W'(idx);
                    is_free[idx] = 1'b1;
                    free_cnt = free_cnt + 1'b1;
                end
            end
        end
        o.free_left = free_cnt;
        return o;
    endfunction

    task automatic note_mismatch(input string what, input logic [ADDR_W-1:0] want,
                                 input logic [ADDR_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg = '0;
            size_reg = MIN_SIZE;
            count_reg = CNT_W'(DEPTH);
            rebuild_pool();
            expected_rsp.delete();
            mismatches = 0;
            errors <= 0;
            waiting <= 0;
        end
        else
        begin
            // Register write resets the pool
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_BASE_ADDR:
                    begin
                        base_reg = cfg_wdata;
                        rebuild_pool();
                    end
                    CFG_BLOCK_SIZE:
                    begin
                        size_reg = cfg_wdata[SIZE_W-1:0];
                        rebuild_pool();
                    end
                    CFG_BLOCK_COUNT:
                    begin
                        count_reg = cfg_wdata[CNT_W-1:0];
                        rebuild_pool();
                    end
                    default: ;
                endcase
            end

            // Accepted request: queue its response
            if (req_valid && req_ready)
                expected_rsp.push_back(serve_request(req_word));

            // Accepted response: compare with the oldest prediction
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                    note_mismatch("response with none expected", '0, rsp_word.granted_addr);
                else
                begin
                    due_word = expected_rsp.pop_front();
                    if (rsp_word.granted_addr !== due_word.granted_addr)
                        note_mismatch("granted_addr", due_word.granted_addr,
                                      rsp_word.granted_addr);
                    if (rsp_word.status !== due_word.status)
                        note_mismatch("status", ADDR_W'(due_word.status),
                                      ADDR_W'(rsp_word.status));
                    if (rsp_word.free_left !== due_word.free_left)
                        note_mismatch("free_left", ADDR_W'(due_word.free_left),
                                      ADDR_W'(rsp_word.free_left));
                end
            end

            errors <= mismatches;
            waiting <= expected_rsp.size();
        end
    end

endmodule

// ===== test/fixed_block_pool_allocator_test.sv =====
// Top of the block pool allocator test: clock, reset, stimulus, response back-pressure, verdict.
`timescale 1ns / 1ps

module fixed_block_pool_allocator_test;
    import fbpa_pkg::*;

    localparam int unsigned RAND_WORDS  = 1126;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned SETTLE      = 4;
    localparam int unsigned CYCLE_LIMIT = 500000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int unsigned errors;
    int unsigned waiting;
    int unsigned cycles;

    // Stimulus view of the pool setup, used to aim free addresses
    logic [ADDR_W-1:0] cur_base;
    int unsigned       cur_size;
    int unsigned       cur_count;

    bit tx_steady;
    bit stall_issued;

    fbpa_stream_if #(.payload_t(fbpa_req_t)) req_ch ();
    fbpa_stream_if #(.payload_t(fbpa_rsp_t)) rsp_ch ();

    fixed_block_pool_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    fbpa_pool_checker pool_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_ch.valid),
        .req_ready (req_ch.ready),
        .req_word  (req_ch.payload),
        .rsp_valid (rsp_ch.valid),
        .rsp_ready (rsp_ch.ready),
        .rsp_word  (rsp_ch.payload),
        .errors    (errors),
        .waiting   (waiting)
    );

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("fixed_block_pool_allocator_test: done, errors");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Free address: mostly block starts inside the pool, the rest bad in various ways
    function automatic logic [ADDR_W-1:0] pick_free_addr();
        int unsigned r;
        int unsigned k;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, cur_count - 1);
        if (r < 60)
            return cur_base + k * cur_size;
        if (r < 70)
            return cur_base + k * cur_size + $urandom_range(1, cur_size - 1);
        if (r < 78)
            return cur_base + cur_count * cur_size + $urandom_range(0, 3 * cur_size);
        if (r < 83)
            return cur_base - $urandom_range(1, 64);
        if (r < 88)
            return '0;
        return $urandom();
    endfunction

    // Offer one request word and hold it until accepted
    task automatic send_word(input logic f, input logic [ADDR_W-1:0] a);
        fbpa_req_t   w;
        logic        taken;
        int unsigned gap;
        w.func = f;
        w.block_addr = a;
        req_ch.valid <= 1'b1;
        req_ch.payload <= w;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = req_ch.ready;
            @(posedge clk);
        end
        gap = tx_steady ? 0 : idle_span();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every response word is back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (waiting != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_BASE_ADDR:
                cur_base = data;
            CFG_BLOCK_SIZE:
                cur_size = 32'((data[SIZE_W-1:0] < MIN_SIZE) ? MIN_SIZE : data[SIZE_W-1:0]);
            CFG_BLOCK_COUNT:
                cur_count = (data[CNT_W-1:0] == 0) ? 1 :
                            (data[CNT_W-1:0] > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF :
                            32'(data[CNT_W-1:0]);
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Response side: random stalls, quiet runs, and one long hold-off
    initial
    begin
        int unsigned gap_left;
        int unsigned run_left;
        bit          stall_served;
        gap_left = 0;
        run_left = 0;
        stall_served = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_issued && !stall_served)
            begin
                stall_served = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (gap_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (run_left > 0)
                    run_left--;
                else if ($urandom_range(0, 99) < 5)
                    run_left = $urandom_range(50, 200);
                else if ($urandom_range(0, 99) < 30)
                    gap_left = idle_span();
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int unsigned sent;
        int unsigned phase;
        int unsigned n_words;
        int unsigned alloc_pct;
        int unsigned kind;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_BASE_ADDR;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        cycles = 0;
        tx_steady = 1'b0;
        stall_issued = 1'b0;
        cur_base = '0;
        cur_size = MIN_SIZE;
        cur_count = MAX_BLOCKS_DEF;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: default pool, base 0, 4-byte blocks, 256 blocks
        send_word(FN_ALLOC, $urandom());          // top block
        send_word(FN_FREE, 32'h0000_03FC);        // back in
        send_word(FN_FREE, 32'h0000_03FC);        // pool already full
        send_word(FN_ALLOC, $urandom());
        send_word(FN_ALLOC, $urandom());
        send_word(FN_FREE, 32'h0000_03F8);
        send_word(FN_FREE, 32'h0000_03F8);        // double free, pool not full
        send_word(FN_FREE, 32'h0000_0000);        // null address
        send_word(FN_FREE, 32'h0000_03FA);        // misaligned
        send_word(FN_FREE, 32'h0000_0400);        // just past the pool
        send_word(FN_FREE, 32'hFFFF_FFFF);        // offset wraps far out

        // Two blocks wrapping over zero, size below minimum
        set_reg(CFG_BASE_ADDR, 32'hFFFF_FFFC);
        set_reg(CFG_BLOCK_SIZE, 32'd0);
        set_reg(CFG_BLOCK_COUNT, 32'd2);
        send_word(FN_ALLOC, $urandom());          // block at address zero
        send_word(FN_ALLOC, $urandom());
        send_word(FN_ALLOC, $urandom());          // empty pool
        send_word(FN_FREE, 32'h0000_0000);        // block at zero cannot be freed
        send_word(FN_FREE, 32'hFFFF_FFFC);
        send_word(FN_FREE, 32'hFFFF_FFFC);        // already free

        // Largest size, zero count taken as one
        set_reg(CFG_BASE_ADDR, 32'h8000_0001);
        set_reg(CFG_BLOCK_SIZE, 32'd65535);
        set_reg(CFG_BLOCK_COUNT, 32'd0);
        send_word(FN_ALLOC, $urandom());
        send_word(FN_ALLOC, $urandom());
        send_word(FN_FREE, 32'h8000_0001);
        send_word(FN_FREE, 32'h8001_0000);        // one block past the end

        // Count above the built depth, size 3 taken as 4, base at the top
        set_reg(CFG_BLOCK_COUNT, 32'd511);
        set_reg(CFG_BLOCK_SIZE, 32'd3);
        set_reg(CFG_BASE_ADDR, 32'hFFFF_FFFF);
        send_word(FN_ALLOC, $urandom());
        send_word(FN_FREE, 32'h0000_03FB);
        send_word(FN_FREE, 32'h0000_03FC);        // misaligned across the wrap

        // Random phases, each with its own pool setup
        sent = 0;
        phase = 0;
        while (sent < RAND_WORDS)
        begin
            kind = (phase == 3 || phase == 14) ? 5 : $urandom_range(0, 4);
            case (kind)
                0, 1:
                begin
                    set_reg(CFG_BLOCK_SIZE, $urandom_range(0, 24));
                    set_reg(CFG_BLOCK_COUNT, $urandom_range(0, 12));
                    if ($urandom_range(0, 1))
                        set_reg(CFG_BASE_ADDR, $urandom());
                end
                2:
                begin
                    set_reg(CFG_BLOCK_SIZE, $urandom_range(0, 65535));
                    set_reg(CFG_BLOCK_COUNT, $urandom_range(1, 40));
                end
                3:
                    set_reg(CFG_BASE_ADDR, ($urandom_range(0, 2) == 0) ? 32'h0 :
                                           ($urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom()));
                default:
                    if (kind == 4)
                        set_reg(CFG_BLOCK_COUNT, $urandom_range(1, 16));
                    else
                    begin
                        set_reg(CFG_BLOCK_SIZE, $urandom_range(0, 1) ? 32'd65535 : 32'd4);
                        set_reg(CFG_BLOCK_COUNT, $urandom_range(256, 511));
                        set_reg(CFG_BASE_ADDR, $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom());
                    end
            endcase
            tx_steady = ($urandom_range(0, 99) < 30);

            // Big pool: drain it past empty, then mostly frees
            if (kind == 5)
            begin
                repeat (cur_count + 4)
                begin
                    send_word(FN_ALLOC, $urandom());
                    sent++;
                    // Long receiver hold-off while the drain keeps offering words
                    stall_issued = 1'b1;
                end
                n_words = 60;
                alloc_pct = 30;
            end
            else
            begin
                n_words = $urandom_range(20, 70);
                alloc_pct = $urandom_range(25, 75);
            end

            repeat (n_words)
            begin
                if ($urandom_range(0, 99) < alloc_pct)
                    send_word(FN_ALLOC, $urandom());
                else
                    send_word(FN_FREE, pick_free_addr());
                sent++;
            end
            phase++;
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (errors == 0 && waiting == 0)
            $display("fixed_block_pool_allocator_test: done, clean");
        else
            $display("fixed_block_pool_allocator_test: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fbpa_pkg.sv
rtl/fbpa_stream_if.sv
rtl/fbpa_ram.sv
rtl/fixed_block_pool_allocator.sv
test/fbpa_pool_checker.sv
test/fixed_block_pool_allocator_test.sv
